FILE: src/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Types, register indexes, event codes and reset values shared by the
// presence timeout detector files.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned EVENT_W   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_TIMEOUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_COOLDOWN   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME       = CFG_IDX_W'(3);

    // register reset values
    localparam logic [TIME_W-1:0] RST_PRESENCE_TIMEOUT = TIME_W'(30000);
    localparam logic [TIME_W-1:0] RST_SETTLE_TIME      = TIME_W'(5000);
    localparam logic [TIME_W-1:0] RST_ALERT_COOLDOWN   = TIME_W'(5 * 60 * 1000);
    localparam logic [TIME_W-1:0] RST_START_TIME       = TIME_W'(0);

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE      = EVENT_W'(0);
    localparam logic [EVENT_W-1:0] EV_RISING    = EVENT_W'(1);
    localparam logic [EVENT_W-1:0] EV_TIMED_OUT = EVENT_W'(2);
    localparam logic [EVENT_W-1:0] EV_CANCELED  = EVENT_W'(3);

    // request codes
    localparam logic FUNC_POLL = 1'b0;
    localparam logic FUNC_TAKE = 1'b1;

    typedef struct packed {
        logic              func;
        logic [TIME_W-1:0] now_time;
        logic              sensor_level;
    } t_in_item;

    typedef struct packed {
        logic [EVENT_W-1:0] event_code;
        logic               latch_taken;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0] presence_timeout;
        logic [TIME_W-1:0] settle_time;
        logic [TIME_W-1:0] alert_cooldown;
        logic [TIME_W-1:0] start_time;
    } t_cfg;

endpackage

FILE: src/ptd_if.sv
// ----------------------------------------------------------------------------
// ptd_if
// Valid/ready channels of the presence timeout detector: sample input,
// result output and register write.
// ----------------------------------------------------------------------------
interface ptd_in_if;
    import ptd_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [TIME_W-1:0] now_time;
    logic              sensor_level;

    modport source (output valid, func, now_time, sensor_level, input ready);
    modport sink   (input valid, func, now_time, sensor_level, output ready);
endinterface

interface ptd_out_if;
    import ptd_pkg::*;

    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_code;
    logic               latch_taken;

    modport source (output valid, event_code, latch_taken, input ready);
    modport sink   (input valid, event_code, latch_taken, output ready);
endinterface

interface ptd_cfg_if;
    import ptd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TIME_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/presence_timeout_detector.sv
// ----------------------------------------------------------------------------
// presence_timeout_detector
// Path: input register, event logic, result register.
// Throughput: one item per cycle while the result is not stalled, set by the
// input register and the result register with the event logic between them.
// Reset: synchronous, active low; clears both stages, the detector state and
// loads the register defaults; configuration writes are always ready.
// ----------------------------------------------------------------------------
module presence_timeout_detector (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptd_in_if.sink    i_in,
    ptd_cfg_if.sink   i_cfg,
    ptd_out_if.source o_out
);
    import ptd_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    t_cfg      cfg;
    t_out_item result;
    logic      advance;
    logic      in_xfer;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    ptd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    ptd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.func         <= i_in.func;
            r_in.now_time     <= i_in.now_time;
            r_in.sensor_level <= i_in.sensor_level;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.event_code  = r_out.event_code;
    assign o_out.latch_taken = r_out.latch_taken;

endmodule

FILE: src/ptd_cfg_regs.sv
// ----------------------------------------------------------------------------
// ptd_cfg_regs
// Configuration register file: timeout, settling time, cooldown and start
// time, written one at a time by index.
// ----------------------------------------------------------------------------
module ptd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [ptd_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [ptd_pkg::TIME_W-1:0]    i_wr_data,
    output ptd_pkg::t_cfg                 o_cfg
);
    import ptd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.presence_timeout <= RST_PRESENCE_TIMEOUT;
            r_cfg.settle_time      <= RST_SETTLE_TIME;
            r_cfg.alert_cooldown   <= RST_ALERT_COOLDOWN;
            r_cfg.start_time       <= RST_START_TIME;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_PRESENCE_TIMEOUT: r_cfg.presence_timeout <= i_wr_data;
                REG_SETTLE_TIME:      r_cfg.settle_time      <= i_wr_data;
                REG_ALERT_COOLDOWN:   r_cfg.alert_cooldown   <= i_wr_data;
                REG_START_TIME:       r_cfg.start_time       <= i_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/ptd_core.sv
// ----------------------------------------------------------------------------
// ptd_core
// Detector state and event logic: settling, rising edge, timeout with
// cooldown, cancellation and the timed-out latch.
// ----------------------------------------------------------------------------
module ptd_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptd_pkg::t_cfg      i_cfg,
    input  logic               i_fire,
    input  ptd_pkg::t_in_item  i_item,
    output ptd_pkg::t_out_item o_result
);
    import ptd_pkg::*;

    logic              r_prev_level;
    logic              r_window_open;
    logic [TIME_W-1:0] r_window_begin;
    logic [TIME_W-1:0] r_last_alert;
    logic              r_alert_latch;

    logic              n_prev_level;
    logic              n_window_open;
    logic [TIME_W-1:0] n_window_begin;
    logic [TIME_W-1:0] n_last_alert;
    logic              n_alert_latch;

    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] since_begin;
    logic [TIME_W-1:0] since_alert;
    logic              settling;
    logic              timeout_hit;
    logic              cooldown_ok;

    assign since_start = i_item.now_time - i_cfg.start_time;
    assign since_begin = i_item.now_time - r_window_begin;
    assign since_alert = i_item.now_time - r_last_alert;
    assign settling    = since_start < i_cfg.settle_time;
    assign timeout_hit = since_begin >= i_cfg.presence_timeout;
    assign cooldown_ok = (r_last_alert == '0) || (since_alert >= i_cfg.alert_cooldown);

    always_comb begin
        n_prev_level         = r_prev_level;
        n_window_open        = r_window_open;
        n_window_begin       = r_window_begin;
        n_last_alert         = r_last_alert;
        n_alert_latch        = r_alert_latch;
        o_result.event_code  = EV_NONE;
        o_result.latch_taken = 1'b0;
        if (i_item.func == FUNC_TAKE) begin
            o_result.latch_taken = r_alert_latch;
            n_alert_latch        = 1'b0;
        end else begin
            n_prev_level = i_item.sensor_level;
            if (settling) begin
                o_result.event_code = EV_NONE;
            end else if (!r_prev_level && i_item.sensor_level) begin
                n_window_open       = 1'b1;
                n_window_begin      = i_item.now_time;
                o_result.event_code = EV_RISING;
            end else if (r_window_open && i_item.sensor_level && timeout_hit
                         && cooldown_ok) begin
                n_alert_latch       = 1'b1;
                n_last_alert        = i_item.now_time;
                o_result.event_code = EV_TIMED_OUT;
            end else if (r_window_open && !i_item.sensor_level) begin
                n_window_open       = 1'b0;
                o_result.event_code = EV_CANCELED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level   <= 1'b0;
            r_window_open  <= 1'b0;
            r_window_begin <= '0;
            r_last_alert   <= '0;
            r_alert_latch  <= 1'b0;
        end else if (i_fire) begin
            r_prev_level   <= n_prev_level;
            r_window_open  <= n_window_open;
            r_window_begin <= n_window_begin;
            r_last_alert   <= n_last_alert;
            r_alert_latch  <= n_alert_latch;
        end
    end

endmodule

FILE: src/ptd_checker.sv
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks of the presence timeout detector, bound to the top level.
// ----------------------------------------------------------------------------
module ptd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [ptd_pkg::EVENT_W-1:0] i_event_code,
    input logic                        i_latch_taken
);
    import ptd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_event_code)
                                        && $stable(i_latch_taken))
        else $error("result changed while stalled");

    // a taken latch only comes with a take request result
    a_taken_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_latch_taken |-> i_event_code == EV_NONE)
        else $error("latch taken together with an event");

    // empty result stage never blocks input
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result stage");

    // reset empties the result stage
    a_reset_clear: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind presence_timeout_detector ptd_checker u_ptd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_event_code  (o_out.event_code),
    .i_latch_taken (o_out.latch_taken)
);
